// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the decimal text unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of clk_i outside reset.
`define ITDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check on every rising edge of clk_i, reset included.
`define ITDA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ----- rtl/core/itda_pkg.sv -----
// ----------------------------------------------------------------------------
// itda_pkg
// Types and constants for the integer to decimal ASCII unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itda_pkg;

  localparam int unsigned CHUNK_W    = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_CODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IS_SIGNED  = 1'b1;

  // Operand width codes
  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;
  localparam logic [1:0] WIDTH_64 = 2'd3;

  localparam logic [1:0] WIDTH_RESET  = WIDTH_32;
  localparam logic       SIGNED_RESET = 1'b1;

  localparam logic [7:0]  CH_ZERO    = 8'h30;
  localparam logic [7:0]  CH_MINUS   = 8'h2D;
  localparam logic [7:0]  CH_NONE    = 8'h00;
  localparam logic [4:0]  MAX_DIGITS = 5'd20;
  // ceil(2^23 / 10): exact quotient by ten for any 20-bit dividend
  localparam logic [19:0] RECIP_TEN  = 20'd838861;

  typedef struct packed {
    logic [63:0] value;
    logic [7:0]  capacity;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       char_valid;
    logic [4:0] needed_length;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic start_emit;
    logic advance;
  } ctrl_cmd_t;

  typedef struct packed {
    logic chunk_last;
    logic conv_done;
    logic last_beat;
  } dp_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SIZE,
    S_EMIT
  } state_e;

endpackage

// ----- rtl/core/itda_ctrl.sv -----
// ----------------------------------------------------------------------------
// itda_ctrl
// Sequencer: takes an item, runs the divide passes, sizes the text and emits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itda_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  itda_pkg::dp_status_t   status_i,
  output itda_pkg::ctrl_cmd_t    cmd_o
);
  import itda_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.chunk_last && status_i.conv_done) begin
          state_d = S_SIZE;
        end
      end
      S_SIZE: begin
        cmd_o.start_emit = 1'b1;
        state_d          = S_EMIT;
      end
      S_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (status_i.last_beat) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/itda_dpath.sv -----
// ----------------------------------------------------------------------------
// itda_dpath
// Operand conditioning, chunked divide by ten, digit store and beat build.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itda_dpath #(
  parameter int unsigned DIGIT_DEPTH = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [itda_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [itda_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  itda_pkg::in_item_t                  in_data_i,
  input  itda_pkg::ctrl_cmd_t                 cmd_i,
  output itda_pkg::dp_status_t                status_o,
  output itda_pkg::out_item_t                 out_data_o
);
  import itda_pkg::*;

  localparam int unsigned IDX_W = (DIGIT_DEPTH > 1) ? $clog2(DIGIT_DEPTH) : 1;
  localparam logic [4:0]  DEPTH_5 = 5'(DIGIT_DEPTH);

  logic [1:0]  width_q, width_d;
  logic        signed_q, signed_d;
  logic [63:0] rem_q, rem_d;
  logic        neg_q, neg_d;
  logic [7:0]  cap_q, cap_d;
  logic [4:0]  count_q, count_d;
  logic [1:0]  chunk_q, chunk_d;
  logic [1:0]  top_q, top_d;
  logic [3:0]  part_q, part_d;
  logic [4:0]  pos_q, pos_d;
  logic        sign_q, sign_d;
  logic        ovf_q, ovf_d;
  logic [3:0]  store_q [DIGIT_DEPTH];

  logic [63:0] mask, val_m, mag;
  logic        sbit, neg_in;
  logic [1:0]  top_in;
  logic [15:0] chunk_val, quot;
  logic [19:0] div_x, q_by10, rem20;
  logic [39:0] prod;
  logic        quot_zero, store_we, fits;
  logic [4:0]  need;
  logic [3:0]  digit_rd;

  // Operand mask, sign and magnitude
  always_comb begin
    case (width_q)
      WIDTH_8: begin
        mask   = 64'h0000_0000_0000_00FF;
        sbit   = in_data_i.value[7];
        top_in = 2'd0;
      end
      WIDTH_16: begin
        mask   = 64'h0000_0000_0000_FFFF;
        sbit   = in_data_i.value[15];
        top_in = 2'd0;
      end
      WIDTH_32: begin
        mask   = 64'h0000_0000_FFFF_FFFF;
        sbit   = in_data_i.value[31];
        top_in = 2'd1;
      end
      default: begin
        mask   = 64'hFFFF_FFFF_FFFF_FFFF;
        sbit   = in_data_i.value[63];
        top_in = 2'd3;
      end
    endcase
  end

  assign val_m  = in_data_i.value & mask;
  assign neg_in = signed_q & sbit;
  assign mag    = neg_in ? ((~val_m + 64'd1) & mask) : val_m;

  // One 16-bit chunk of the long division by ten per cycle, top chunk first
  assign chunk_val = rem_q[{chunk_q, 4'b0000} +: CHUNK_W];
  assign div_x     = {part_q, chunk_val};
  assign prod      = 40'(div_x) * 40'(RECIP_TEN);
  assign quot      = prod[38:23];
  assign q_by10    = 20'({quot, 3'b000}) + 20'({quot, 1'b0});
  assign rem20     = div_x - q_by10;
  assign quot_zero = (quot == 16'd0) && (rem_q[63:CHUNK_W] == '0);
  assign store_we  = cmd_i.div_step && (chunk_q == 2'd0) && (count_q < DEPTH_5);

  assign need = count_q + 5'(neg_q);
  assign fits = ({3'b000, need} <= cap_q);

  assign status_o.chunk_last = (chunk_q == 2'd0);
  assign status_o.conv_done  = quot_zero || (count_q == MAX_DIGITS - 5'd1);

  always_comb begin
    width_d  = width_q;
    signed_d = signed_q;
    rem_d    = rem_q;
    neg_d    = neg_q;
    cap_d    = cap_q;
    count_d  = count_q;
    chunk_d  = chunk_q;
    top_d    = top_q;
    part_d   = part_q;
    pos_d    = pos_q;
    sign_d   = sign_q;
    ovf_d    = ovf_q;

    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WIDTH_CODE: width_d  = cfg_wdata_i[1:0];
        REG_IS_SIGNED:  signed_d = cfg_wdata_i[0];
        default: ;
      endcase
    end

    if (cmd_i.load) begin
      rem_d   = mag;
      neg_d   = neg_in;
      cap_d   = in_data_i.capacity;
      count_d = 5'd0;
      chunk_d = top_in;
      top_d   = top_in;
      part_d  = 4'd0;
    end

    if (cmd_i.div_step) begin
      rem_d[{chunk_q, 4'b0000} +: CHUNK_W] = quot;
      if (chunk_q == 2'd0) begin
        // digit complete: restart the pass on the quotient
        part_d  = 4'd0;
        chunk_d = top_q;
        count_d = count_q + 5'd1;
      end else begin
        part_d  = rem20[3:0];
        chunk_d = chunk_q - 2'd1;
      end
    end

    if (cmd_i.start_emit) begin
      ovf_d  = !fits;
      sign_d = neg_q && fits;
      pos_d  = count_q - 5'd1;
    end

    if (cmd_i.advance) begin
      if (sign_q) begin
        sign_d = 1'b0;
      end else begin
        pos_d = pos_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      signed_q <= SIGNED_RESET;
      count_q  <= '0;
      rem_q    <= '0;
      neg_q    <= 1'b0;
      chunk_q  <= '0;
      top_q    <= '0;
      part_q   <= '0;
      pos_q    <= '0;
      sign_q   <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      width_q  <= width_d;
      signed_q <= signed_d;
      count_q  <= count_d;
      rem_q    <= rem_d;
      neg_q    <= neg_d;
      chunk_q  <= chunk_d;
      top_q    <= top_d;
      part_q   <= part_d;
      pos_q    <= pos_d;
      sign_q   <= sign_d;
      ovf_q    <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cap_q <= cap_d;
    if (store_we) begin
      store_q[count_q[IDX_W-1:0]] <= rem20[3:0];
    end
  end

  // Digits beyond the store read as zero
  assign digit_rd = (pos_q < DEPTH_5) ? store_q[pos_q[IDX_W-1:0]] : 4'd0;

  always_comb begin
    out_data_o.needed_length = need;
    out_data_o.char_valid    = !ovf_q;
    out_data_o.last          = ovf_q || (!sign_q && (pos_q == 5'd0));
    if (ovf_q) begin
      out_data_o.char_code = CH_NONE;
    end else if (sign_q) begin
      out_data_o.char_code = CH_MINUS;
    end else begin
      out_data_o.char_code = CH_ZERO + {4'b0000, digit_rd};
    end
  end

  assign status_o.last_beat = out_data_o.last;

endmodule

// ----- rtl/core/integer_to_decimal_ascii_unit.sv -----
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_unit
// Converts an 8, 16, 32 or 64-bit integer, signed or unsigned by configuration,
// into decimal ASCII, most significant character first, last beat marked. When
// the text is longer than the capacity a single beat carries only the needed
// length. One item is in flight at a time: after the accept the divide by ten
// runs one 16-bit chunk per cycle, over 1, 1, 2 or 4 chunks per digit for 8,
// 16, 32 or 64-bit operands; then the sizing state, then the output beats,
// each held while the output is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_to_decimal_ascii_unit #(
  parameter int unsigned DIGIT_DEPTH = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [itda_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [itda_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  itda_pkg::in_item_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output itda_pkg::out_item_t              out_data_o
);
  import itda_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  itda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  itda_dpath #(
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/core/itda_checker.sv -----
// ----------------------------------------------------------------------------
// itda_checker
// Port-level checks on the decimal text unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module itda_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input itda_pkg::out_item_t              out_data_o
);
  import itda_pkg::*;

  logic       in_beat, out_beat, out_hold, mid_beat, char_ok, text_ok;
  logic [4:0] need_len;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;
  assign out_hold = out_valid_o && out_stall_i;
  assign mid_beat = out_beat && !out_data_o.last;
  assign need_len = out_data_o.needed_length;
  assign char_ok  = ((out_data_o.char_code >= CH_ZERO) &&
                     (out_data_o.char_code <= CH_ZERO + 8'd9)) ||
                    (out_data_o.char_code == CH_MINUS);
  // A length-only beat carries no character and must close the text
  assign text_ok  = out_data_o.char_valid ? char_ok : out_data_o.last;

  `ITDA_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "beat shown during reset")
  `ITDA_ASSERT(a_busy_after_take, in_beat |=> in_stall_o, "second item taken while busy")
  `ITDA_ASSERT(a_stall_hold, out_hold |=> out_valid_o && $stable(out_data_o), "stalled beat moved")
  `ITDA_ASSERT(a_text_rules, out_valid_o |-> text_ok, "bad character or unterminated length beat")
  `ITDA_ASSERT(a_len_steady, mid_beat |=> out_valid_o && $stable(need_len), "length moved mid text")

endmodule

bind integer_to_decimal_ascii_unit itda_checker u_itda_checker (.*);
